/* rtl/snes_pad_serial_port_assert.svh */
// Assertion macros used by the checker file of the pad serial port.
`ifndef SNES_PAD_SERIAL_PORT_ASSERT_SVH
`define SNES_PAD_SERIAL_PORT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SNES_PAD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SNES_PAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/snes_pad_pkg.sv */
`default_nettype none

package snes_pad_pkg;

	// Command codes carried in the action field.
	typedef enum logic [1:0] {
		ACT_PORT_WRITE = 2'd0,
		ACT_SET_ALL    = 2'd1,
		ACT_SET_ONE    = 2'd2
	} action_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOUSE_EN       = 3'd0,
		CFG_GUN_EN         = 3'd1,
		CFG_KEYBOARD_EN    = 3'd2,
		CFG_MOUSE_SIG_MASK = 3'd3,
		CFG_GUN_TRIG_MASK  = 3'd4,
		CFG_GUN_LIGHT_MASK = 3'd5
	} cfg_idx_t;

	localparam int CFG_DATA_W = 32;
	localparam int PAD_W      = 32;
	localparam int BUTTONS_W  = 12;

	localparam logic [7:0]       LATCH_EDGE = 8'h04;
	localparam logic [7:0]       CLOCK_EDGE = 8'h08;
	localparam logic [PAD_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [PAD_W-1:0] PAD_UP     = 32'h0000_0010;
	localparam logic [PAD_W-1:0] PAD_DOWN   = 32'h0000_0020;
	localparam logic [PAD_W-1:0] PAD_LEFT   = 32'h0000_0040;
	localparam logic [PAD_W-1:0] PAD_RIGHT  = 32'h0000_0080;

	// One command beat as held in the input register.
	typedef struct packed {
		logic [1:0]           action;
		logic [7:0]           prev_port;
		logic [7:0]           curr_port;
		logic                 gun_trigger;
		logic                 gun_light;
		logic [1:0]           player;
		logic [BUTTONS_W-1:0] button_mask;
		logic [4:0]           button_index;
		logic                 pressed;
	} cmd_t;

	// Result handed from the core to the output register.
	typedef struct packed {
		logic       valid;
		logic [1:0] pin_data;
	} res_t;

	// Opposing directions pressed together: down and right read as released.
	function automatic logic [PAD_W-1:0] filter_pad(input logic [PAD_W-1:0] b);
		logic [PAD_W-1:0] r;
		r = b;
		if ((r & (PAD_UP | PAD_DOWN)) == '0) begin
			r = r | PAD_DOWN;
		end
		if ((r & (PAD_LEFT | PAD_RIGHT)) == '0) begin
			r = r | PAD_RIGHT;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/snes_pad_if.sv */
`default_nettype none

// Command channel: one beat per port write or button update.
interface snes_pad_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  prev_port;
	logic [7:0]  curr_port;
	logic        gun_trigger;
	logic        gun_light;
	logic [1:0]  player;
	logic [11:0] button_mask;
	logic [4:0]  button_index;
	logic        pressed;

	modport source (
		output valid, action, prev_port, curr_port, gun_trigger, gun_light,
		player, button_mask, button_index, pressed,
		input  ready
	);
	modport sink (
		input  valid, action, prev_port, curr_port, gun_trigger, gun_light,
		player, button_mask, button_index, pressed,
		output ready
	);
endinterface

// Response channel: the serial pin bits of both pads.
interface snes_pad_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] pin_data;

	modport source (output valid, pin_data, input ready);
	modport sink (input valid, pin_data, output ready);
endinterface

`default_nettype wire

/* rtl/snes_pad_serial_port.sv */
// Two-player SNES pad serial port, as seen from a CPU output port.
// Channels: cmd carries one beat per port write or button update (valid/ready);
// rsp returns the two serial pin bits for every port write; cfg_we, cfg_index
// and cfg_data write the mouse, gun and keyboard registers, one per cycle.
// Path: a port write accepted on cmd is held in the input register, and its pin
// bits are registered in the output register before they go out on rsp. Button
// updates produce no beat on rsp.
// Throughput: one command per cycle while rsp does not stall, set by the single
// input register and the single output register around the pad logic.
// Reset: both pads read all buttons released, both shift registers hold all
// ones, and every configuration register clears.
// Stall: while rsp is held off, the pending pin bits stay in the output
// register and one more port write waits in the input register; cmd.ready then
// drops until rsp.ready returns. Button updates still pass while a result
// waits. cmd.ready depends combinationally on rsp.ready.
// The user must write configuration only while no command is in flight; the block does not enforce it.
`default_nettype none

module snes_pad_serial_port (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	snes_pad_cmd_if.sink                             cmd,
	snes_pad_rsp_if.source                           rsp,
	input  wire logic                                cfg_we,
	input  wire logic [snes_pad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [snes_pad_pkg::CFG_DATA_W-1:0] cfg_data
);
	import snes_pad_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	logic fire;
	logic out_free;
	res_t res;

	snes_pad_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1)
	);

	snes_pad_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.cmd_s1    (cmd_s1),
		.out_free  (out_free),
		.fire      (fire),
		.res       (res)
	);

	snes_pad_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

/* rtl/snes_pad_in_reg.sv */
`default_nettype none

module snes_pad_in_reg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	snes_pad_cmd_if.sink      cmd,
	input  wire logic         fire,
	output logic              valid_s1,
	output snes_pad_pkg::cmd_t cmd_s1
);
	import snes_pad_pkg::*;

	logic accept;

	// A new beat enters when the stage is empty or drains this cycle.
	assign cmd.ready = !valid_s1 || fire;
	assign accept    = cmd.valid && cmd.ready;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Command payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.action       <= cmd.action;
			cmd_s1.prev_port    <= cmd.prev_port;
			cmd_s1.curr_port    <= cmd.curr_port;
			cmd_s1.gun_trigger  <= cmd.gun_trigger;
			cmd_s1.gun_light    <= cmd.gun_light;
			cmd_s1.player       <= cmd.player;
			cmd_s1.button_mask  <= cmd.button_mask;
			cmd_s1.button_index <= cmd.button_index;
			cmd_s1.pressed      <= cmd.pressed;
		end
	end

endmodule

`default_nettype wire

/* rtl/snes_pad_core.sv */
`default_nettype none

module snes_pad_core (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [snes_pad_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [snes_pad_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                                 valid_s1,
	input  wire snes_pad_pkg::cmd_t                   cmd_s1,
	input  wire logic                                 out_free,
	output logic                                      fire,
	output snes_pad_pkg::res_t                        res
);
	import snes_pad_pkg::*;

	logic             mouse_en_q;
	logic             gun_en_q;
	logic             kb_en_q;
	logic [PAD_W-1:0] mouse_sig_mask_q;
	logic [PAD_W-1:0] gun_trig_mask_q;
	logic [PAD_W-1:0] gun_light_mask_q;

	logic [PAD_W-1:0] held_q  [2];
	logic [PAD_W-1:0] shift_q [2];

	logic             is_write;
	logic [7:0]       rise;
	logic             do_latch;
	logic             do_clock;
	logic [PAD_W-1:0] p1_latch;
	logic [PAD_W-1:0] p2_latch;
	logic [PAD_W-1:0] gun_flip;
	logic [PAD_W-1:0] set_all_val;
	logic [PAD_W-1:0] one_bit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_en_q       <= 1'b0;
			gun_en_q         <= 1'b0;
			kb_en_q          <= 1'b0;
			mouse_sig_mask_q <= '0;
			gun_trig_mask_q  <= '0;
			gun_light_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MOUSE_EN:       mouse_en_q       <= cfg_data[0];
				CFG_GUN_EN:         gun_en_q         <= cfg_data[0];
				CFG_KEYBOARD_EN:    kb_en_q          <= cfg_data[0];
				CFG_MOUSE_SIG_MASK: mouse_sig_mask_q <= cfg_data;
				CFG_GUN_TRIG_MASK:  gun_trig_mask_q  <= cfg_data;
				CFG_GUN_LIGHT_MASK: gun_light_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A port write needs room in the output register; button updates never wait.
	assign is_write = (cmd_s1.action == ACT_PORT_WRITE);
	assign fire     = valid_s1 && (!is_write || out_free);

	// Only a lone rising edge on the latch or the clock bit acts.
	assign rise     = cmd_s1.curr_port & ~cmd_s1.prev_port;
	assign do_latch = fire && is_write && (rise == LATCH_EDGE);
	assign do_clock = fire && is_write && (rise == CLOCK_EDGE);

	// Port 1 latch value with the mouse signature or light gun overlay.
	assign gun_flip = ({PAD_W{cmd_s1.gun_trigger}} & gun_trig_mask_q) |
	                  ({PAD_W{cmd_s1.gun_light}} & gun_light_mask_q);

	always_comb begin
		p1_latch = filter_pad(held_q[0]);
		if (mouse_en_q) begin
			p1_latch = p1_latch & ~mouse_sig_mask_q;
		end else if (gun_en_q) begin
			p1_latch = (p1_latch | gun_trig_mask_q | gun_light_mask_q) ^ gun_flip;
		end
	end

	assign p2_latch = filter_pad(held_q[1]);

	// Button update values: on a set-all update, bits above the pad's buttons read released.
	assign set_all_val = {{(PAD_W-BUTTONS_W){1'b1}}, ~cmd_s1.button_mask};
	assign one_bit     = PAD_W'(1) << cmd_s1.button_index;

	// Pad button state and shift registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				held_q[i]  <= ALL_ONES;
				shift_q[i] <= ALL_ONES;
			end
		end else begin
			for (int i = 0; i < 2; i++) begin
				if (fire && (cmd_s1.player == 2'(i))) begin
					case (cmd_s1.action)
						ACT_SET_ALL: held_q[i] <= set_all_val;
						ACT_SET_ONE: begin
							if (cmd_s1.pressed) begin
								held_q[i] <= held_q[i] & ~one_bit;
							end else begin
								held_q[i] <= held_q[i] | one_bit;
							end
						end
						default: ;
					endcase
				end
			end
			if (do_latch) begin
				shift_q[0] <= p1_latch;
				if (!kb_en_q) begin
					shift_q[1] <= p2_latch;
				end
			end else if (do_clock) begin
				shift_q[0] <= shift_q[0] >> 1;
				if (!kb_en_q) begin
					shift_q[1] <= shift_q[1] >> 1;
				end
			end
		end
	end

	// Pin bits are sampled before any edge acts.
	assign res.valid    = fire && is_write;
	assign res.pin_data = {shift_q[1][0] & ~kb_en_q, shift_q[0][0]};

endmodule

`default_nettype wire

/* rtl/snes_pad_out_reg.sv */
`default_nettype none

module snes_pad_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire snes_pad_pkg::res_t res,
	output logic                    out_free,
	snes_pad_rsp_if.source          rsp
);
	import snes_pad_pkg::*;

	logic       valid_q;
	logic [1:0] pin_data_q;

	// The register can take a result when empty or when its beat leaves now.
	assign out_free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			pin_data_q <= res.pin_data;
		end
	end

	assign rsp.valid    = valid_q;
	assign rsp.pin_data = pin_data_q;

endmodule

`default_nettype wire

/* rtl/snes_pad_checker.sv */
`default_nettype none
`include "snes_pad_serial_port_assert.svh"

module snes_pad_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                cmd_valid,
	input wire logic                                cmd_ready,
	input wire logic                                rsp_valid,
	input wire logic                                rsp_ready,
	input wire logic [1:0]                          rsp_pin_data,
	input wire logic                                cfg_we,
	input wire logic [snes_pad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire logic [snes_pad_pkg::CFG_DATA_W-1:0] cfg_data
);
	import snes_pad_pkg::*;

	logic kb_q;

	// Shadow of the keyboard enable as seen on the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kb_q <= 1'b0;
		end else if (cfg_we && (cfg_index == CFG_KEYBOARD_EN)) begin
			kb_q <= cfg_data[0];
		end
	end

	// A stalled response beat keeps its pin bits.
	`SNES_PAD_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pin_data))

	// Commands are held off only by a stalled response.
	`SNES_PAD_ASSERT_SAME(a_backpressure, clk, arst_n, !cmd_ready, rsp_valid && !rsp_ready)

	// With the keyboard on port 2, its pin bit reads zero.
	`SNES_PAD_ASSERT_SAME(a_kb_pin_low, clk, arst_n, rsp_valid && kb_q, !rsp_pin_data[1])

endmodule

bind snes_pad_serial_port snes_pad_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_pin_data (rsp.pin_data),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);

`default_nettype wire

/* tb/snes_pad_serial_port_checker.sv */
module snes_pad_serial_port_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	snes_pad_cmd_if                                  cmd,
	snes_pad_rsp_if                                  rsp,
	input  wire logic                                cfg_we,
	input  wire snes_pad_pkg::cfg_idx_t              cfg_index,
	input  wire logic [snes_pad_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                       mismatches,
	output int                                       pin_due_count,
	output int                                       pins_checked,
	output int                                       latch_count,
	output int                                       shift_count,
	output int                                       pad_updates
);
	timeunit 1ns;
	timeprecision 1ps;
	import snes_pad_pkg::*;

	// Shadow copy of both pads and of the port configuration.
	logic [PAD_W-1:0]      held_pad [2];
	logic [PAD_W-1:0]      serial_pad [2];
	logic                  mouse_on;
	logic                  gun_on;
	logic                  keyboard_on;
	logic [CFG_DATA_W-1:0] signature_bits;
	logic [CFG_DATA_W-1:0] trigger_bits;
	logic [CFG_DATA_W-1:0] light_bits;

	// Pin bits owed on the response channel, oldest first.
	logic [1:0] pin_bits_due [$];

	// Prints one line for each of the first 40 mismatches and counts them all.
	task automatic log_pin_error(input string msg);
		if (mismatches < 40) begin
			$display("%0t ns: %s", $time, msg);
		end
		mismatches++;
	endtask

	// A pad with both opposing directions held reads down or right as released.
	function automatic logic [PAD_W-1:0] settle_directions(input logic [PAD_W-1:0] pad);
		logic [PAD_W-1:0] out;
		out = pad;
		if (!(|(pad & PAD_UP)) && !(|(pad & PAD_DOWN))) begin
			out = out | PAD_DOWN;
		end
		if (!(|(pad & PAD_LEFT)) && !(|(pad & PAD_RIGHT))) begin
			out = out | PAD_RIGHT;
		end
		return out;
	endfunction

	// Loads the port 1 shift register, and port 2 unless the keyboard is on, from the held buttons.
	task automatic latch_pads(input logic trig, input logic light);
		logic [PAD_W-1:0] port1;
		port1 = settle_directions(held_pad[0]);
		if (mouse_on) begin
			port1 = port1 & ~signature_bits;
		end else if (gun_on) begin
			// The gun signals are active low; a bit shared by both masks flips once if either signal is set.
			port1 = port1 | trigger_bits | light_bits;
			port1 = port1 ^ ((trig ? trigger_bits : '0) | (light ? light_bits : '0));
		end
		serial_pad[0] = port1;
		if (!keyboard_on) begin
			serial_pad[1] = settle_directions(held_pad[1]);
		end
	endtask

	// Works out the effect of one accepted command beat.
	task automatic predict_pad_command(input cmd_t c);
		logic [7:0]       risen;
		logic [1:0]       pins;
		logic [PAD_W-1:0] button_bit;
		if (c.action == ACT_PORT_WRITE) begin
			risen = (c.prev_port ^ c.curr_port) & c.curr_port;
			pins[0] = serial_pad[0][0];
			pins[1] = keyboard_on ? 1'b0 : serial_pad[1][0];
			pin_bits_due.push_back(pins);
			if (risen == LATCH_EDGE) begin
				latch_pads(c.gun_trigger, c.gun_light);
				latch_count++;
			end else if (risen == CLOCK_EDGE) begin
				serial_pad[0] = serial_pad[0] >> 1;
				if (!keyboard_on) begin
					serial_pad[1] = serial_pad[1] >> 1;
				end
				shift_count++;
			end
		end else if (!c.player[1]) begin
			// Only players 0 and 1 exist; the unused action code does nothing.
			if (c.action == ACT_SET_ALL) begin
				held_pad[c.player[0]] = ~{{(PAD_W-BUTTONS_W){1'b0}}, c.button_mask};
				pad_updates++;
			end else if (c.action == ACT_SET_ONE) begin
				button_bit = {{(PAD_W-1){1'b0}}, 1'b1} << c.button_index;
				if (c.pressed) begin
					held_pad[c.player[0]] = held_pad[c.player[0]] & ~button_bit;
				end else begin
					held_pad[c.player[0]] = held_pad[c.player[0]] | button_bit;
				end
				pad_updates++;
			end
		end
	endtask

	// Compares one response beat with the oldest prediction.
	task automatic check_pin_beat(input logic [1:0] got);
		logic [1:0] want;
		if (pin_bits_due.size() == 0) begin
			log_pin_error($sformatf("pin_data beat %b arrived with nothing expected", got));
		end else begin
			want = pin_bits_due.pop_front();
			if (got !== want) begin
				log_pin_error($sformatf("pin_data mismatch: got %b, expected %b", got, want));
			end
			pins_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cmd_t beat;
		if (!arst_n) begin
			held_pad[0] = ALL_ONES;
			held_pad[1] = ALL_ONES;
			serial_pad[0] = ALL_ONES;
			serial_pad[1] = ALL_ONES;
			mouse_on = 1'b0;
			gun_on = 1'b0;
			keyboard_on = 1'b0;
			signature_bits = '0;
			trigger_bits = '0;
			light_bits = '0;
			pin_bits_due.delete();
			mismatches = 0;
			pins_checked = 0;
			latch_count = 0;
			shift_count = 0;
			pad_updates = 0;
			pin_due_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MOUSE_EN: begin
						mouse_on = cfg_data[0];
					end
					CFG_GUN_EN: begin
						gun_on = cfg_data[0];
					end
					CFG_KEYBOARD_EN: begin
						keyboard_on = cfg_data[0];
					end
					CFG_MOUSE_SIG_MASK: begin
						signature_bits = cfg_data;
					end
					CFG_GUN_TRIG_MASK: begin
						trigger_bits = cfg_data;
					end
					CFG_GUN_LIGHT_MASK: begin
						light_bits = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				check_pin_beat(rsp.pin_data);
			end
			if (cmd.valid && cmd.ready) begin
				beat.action = cmd.action;
				beat.prev_port = cmd.prev_port;
				beat.curr_port = cmd.curr_port;
				beat.gun_trigger = cmd.gun_trigger;
				beat.gun_light = cmd.gun_light;
				beat.player = cmd.player;
				beat.button_mask = cmd.button_mask;
				beat.button_index = cmd.button_index;
				beat.pressed = cmd.pressed;
				predict_pad_command(beat);
			end
			pin_due_count <= pin_bits_due.size();
		end
	end

endmodule

/* tb/snes_pad_serial_port_tb.sv */
module snes_pad_serial_port_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import snes_pad_pkg::*;

	// The fourth action code has no name in the package; the port ignores it.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_BEATS = 250;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int  mismatch_total;
	int  pin_due_count;
	int  pins_checked;
	int  latch_count;
	int  shift_count;
	int  pad_updates;
	int  beats_sent;
	int  settings_loaded;
	int  idle_cycles;
	bit  calm;

	snes_pad_cmd_if cmd_ch ();
	snes_pad_rsp_if rsp_ch ();

	snes_pad_serial_port dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	snes_pad_serial_port_checker pad_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_ch),
		.rsp           (rsp_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatch_total),
		.pin_due_count (pin_due_count),
		.pins_checked  (pins_checked),
		.latch_count   (latch_count),
		.shift_count   (shift_count),
		.pad_updates   (pad_updates)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gap length: mostly none or short, now and then long; none at all when calm.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 50) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// A beat with every field random, the action code included.
	function automatic cmd_t noise_beat();
		logic [63:0] bits;
		cmd_t        c;
		bits = {$urandom, $urandom};
		c = bits[$bits(cmd_t)-1:0];
		return c;
	endfunction

	function automatic cmd_t port_beat(input logic [7:0] prev, input logic [7:0] curr);
		cmd_t c;
		c = noise_beat();
		c.action = ACT_PORT_WRITE;
		c.prev_port = prev;
		c.curr_port = curr;
		return c;
	endfunction

	// Port write where exactly the given bits rise; other bits hold or fall.
	function automatic cmd_t rising_beat(input logic [7:0] rise_bits);
		logic [7:0] prev;
		logic [7:0] curr;
		prev = 8'($urandom) & ~rise_bits;
		curr = (prev & 8'($urandom)) | rise_bits;
		return port_beat(prev, curr);
	endfunction

	function automatic cmd_t set_all_beat(input logic [1:0] player,
			input logic [BUTTONS_W-1:0] mask);
		cmd_t c;
		c = noise_beat();
		c.action = ACT_SET_ALL;
		c.player = player;
		c.button_mask = mask;
		return c;
	endfunction

	function automatic cmd_t set_one_beat(input logic [1:0] player, input logic [4:0] idx,
			input logic press);
		cmd_t c;
		c = noise_beat();
		c.action = ACT_SET_ONE;
		c.player = player;
		c.button_index = idx;
		c.pressed = press;
		return c;
	endfunction

	// Button update, mostly for a real pad, with the conflict masks favored.
	function automatic cmd_t button_beat();
		logic [1:0]           player;
		logic [BUTTONS_W-1:0] mask;
		player = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
			: 2'($urandom_range(0, 1));
		if ($urandom_range(0, 1) == 0) begin
			case ($urandom_range(0, 5))
				0: mask = '1;
				1: mask = '0;
				2: mask = BUTTONS_W'(PAD_UP | PAD_DOWN);
				3: mask = BUTTONS_W'(PAD_LEFT | PAD_RIGHT);
				default: mask = BUTTONS_W'($urandom);
			endcase
			return set_all_beat(player, mask);
		end
		return set_one_beat(player, ($urandom_range(0, 3) == 0) ? 5'($urandom_range(12, 31))
			: 5'($urandom_range(0, 11)), 1'($urandom));
	endfunction

	// Odd traffic: random beats, both edges at once, an edge with other bits rising.
	function automatic cmd_t odd_beat();
		int extra;
		extra = $urandom_range(0, 6);
		if (extra >= 2) begin
			extra++;
		end
		case ($urandom_range(0, 4))
			0: return noise_beat();
			1: return rising_beat(LATCH_EDGE | CLOCK_EDGE);
			2: return rising_beat(LATCH_EDGE | (8'h01 << extra));
			3: return rising_beat(CLOCK_EDGE | (8'h01 << extra));
			default: return port_beat(8'($urandom), 8'($urandom));
		endcase
	endfunction

	// Offers one command beat after a random gap and holds it until taken.
	task automatic send_beat(input cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= c.action;
		cmd_ch.prev_port <= c.prev_port;
		cmd_ch.curr_port <= c.curr_port;
		cmd_ch.gun_trigger <= c.gun_trigger;
		cmd_ch.gun_light <= c.gun_light;
		cmd_ch.player <= c.player;
		cmd_ch.button_mask <= c.button_mask;
		cmd_ch.button_index <= c.button_index;
		cmd_ch.pressed <= c.pressed;
		do @(posedge clk); while (!cmd_ch.ready);
		beats_sent++;
	endtask

	// Stops traffic and waits until every owed beat is back and the pipe is empty.
	task automatic drain_port();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pin_due_count != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic load_setting(input logic mouse, input logic gun, input logic keyboard,
			input logic [CFG_DATA_W-1:0] sig, input logic [CFG_DATA_W-1:0] trig,
			input logic [CFG_DATA_W-1:0] light);
		drain_port();
		write_reg(CFG_MOUSE_EN, CFG_DATA_W'(mouse));
		write_reg(CFG_GUN_EN, CFG_DATA_W'(gun));
		write_reg(CFG_KEYBOARD_EN, CFG_DATA_W'(keyboard));
		write_reg(CFG_MOUSE_SIG_MASK, sig);
		write_reg(CFG_GUN_TRIG_MASK, trig);
		write_reg(CFG_GUN_LIGHT_MASK, light);
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// One frame: mostly a full pad read (updates, latch, clock pulses), else odd traffic.
	task automatic run_frame();
		int n;
		calm = ($urandom_range(0, 99) < 15);
		if ($urandom_range(0, 99) < 70) begin
			n = $urandom_range(0, 3);
			repeat (n) send_beat(button_beat());
			send_beat(rising_beat(LATCH_EDGE));
			n = ($urandom_range(0, 9) < 7) ? 16 : $urandom_range(0, 40);
			repeat (n) begin
				send_beat(rising_beat(CLOCK_EDGE));
				if ($urandom_range(0, 9) < 6) begin
					send_beat(rising_beat('0));
				end
			end
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) send_beat(odd_beat());
		end
	endtask

	// Response side: random stalls with runs of steady ready between them.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Ends the run when nothing has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
			$display("[snes_pad_serial_port] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int         target;
		logic [31:0] bit_a;
		logic [31:0] bit_b;
		arst_n = 1'b0;
		calm = 1'b0;
		beats_sent = 0;
		settings_loaded = 0;
		idle_cycles <= 0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.action <= ACT_PORT_WRITE;
		cmd_ch.prev_port <= '0;
		cmd_ch.curr_port <= '0;
		cmd_ch.gun_trigger <= 1'b0;
		cmd_ch.gun_light <= 1'b0;
		cmd_ch.player <= '0;
		cmd_ch.button_mask <= '0;
		cmd_ch.button_index <= '0;
		cmd_ch.pressed <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MOUSE_EN;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration.
		send_beat(port_beat(8'h00, 8'h00));
		send_beat(port_beat(8'hFF, 8'h00));
		send_beat(set_all_beat(2'd0, '1));
		send_beat(set_all_beat(2'd1, '0));
		send_beat(set_all_beat(2'd2, '1));
		send_beat(set_all_beat(2'd3, '1));
		send_beat(set_one_beat(2'd1, 5'd31, 1'b1));
		send_beat(set_one_beat(2'd1, 5'd0, 1'b1));
		send_beat(set_one_beat(2'd0, 5'd0, 1'b0));
		send_beat(set_one_beat(2'd3, 5'd1, 1'b1));
		begin
			cmd_t c;
			c = noise_beat();
			c.action = ACT_UNUSED;
			send_beat(c);
		end
		send_beat(port_beat(8'h00, 8'hFF));
		send_beat(port_beat(8'h00, LATCH_EDGE | CLOCK_EDGE));
		send_beat(port_beat(8'h00, LATCH_EDGE | 8'h01));
		send_beat(port_beat(8'hF3, 8'hF7));
		send_beat(port_beat(8'h00, 8'h08));
		send_beat(port_beat(8'h08, 8'h00));
		send_beat(port_beat(8'hF7, 8'hFF));
		send_beat(port_beat(8'h37, 8'h0F));
		send_beat(set_one_beat(2'd0, 5'd4, 1'b1));
		send_beat(port_beat(8'h00, LATCH_EDGE));
		send_beat(port_beat(8'h00, CLOCK_EDGE));
		send_beat(port_beat(8'h00, CLOCK_EDGE));
		send_beat(port_beat(8'h00, CLOCK_EDGE));

		// Random part, one configuration per phase.
		for (int ph = 0; ph < 8; ph++) begin
			bit_a = 32'h1 << $urandom_range(0, 31);
			bit_b = ($urandom_range(0, 1) == 0) ? bit_a : (32'h1 << $urandom_range(0, 31));
			case (ph)
				0: load_setting(1'b0, 1'b0, 1'b0, $urandom, $urandom, $urandom);
				1: load_setting(1'b1, 1'b0, 1'b0, $urandom, '0, '0);
				2: load_setting(1'b0, 1'b1, 1'b0, '0, '1, '1);
				3: load_setting(1'b0, 1'b1, 1'b1, '0, bit_a, bit_b);
				4: load_setting(1'b1, 1'b1, 1'b1, '1, $urandom, $urandom);
				5: load_setting(1'b0, 1'b1, 1'b0, $urandom, $urandom, $urandom | bit_a);
				6: load_setting(1'b0, 1'b0, 1'b1, '1, '1, '0);
				default: load_setting(1'b1, 1'b0, 1'b0, bit_a, '0, '1);
			endcase
			target = beats_sent + PHASE_BEATS;
			while (beats_sent < target) begin
				run_frame();
			end
		end

		drain_port();
		repeat (4) @(posedge clk);
		$display("covered %0d command beats over %0d port settings; %0d pin results checked",
			beats_sent, settings_loaded, pins_checked);
		$display("pads latched %0d times, shifted %0d times, button updates %0d",
			latch_count, shift_count, pad_updates);
		if (mismatch_total == 0 && pin_due_count == 0) begin
			$display("[snes_pad_serial_port] OK");
		end else begin
			$display("[snes_pad_serial_port] ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/snes_pad_pkg.sv
rtl/snes_pad_if.sv
rtl/snes_pad_in_reg.sv
rtl/snes_pad_core.sv
rtl/snes_pad_out_reg.sv
rtl/snes_pad_serial_port.sv
rtl/snes_pad_checker.sv
tb/snes_pad_serial_port_checker.sv
tb/snes_pad_serial_port_tb.sv
